// ===== hdl/ising_metropolis_site_update_unit_assert.svh =====
// assertion macros for the spin-flip update unit
// no dependencies; included by the checker file
`ifndef ISING_METROPOLIS_SITE_UPDATE_UNIT_ASSERT_SVH
`define ISING_METROPOLIS_SITE_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ISU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isu: same-cycle check failed");

// next-cycle implication, disabled during reset
`define ISU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isu: next-cycle check failed");

`endif

// ===== hdl/isu_pkg.sv =====
// shared types, constants and elaboration helpers for the spin-flip update unit
// no dependencies; used by the controller, datapath and top level
package isu_pkg;

    // spin store geometry
    localparam int ADDR_W      = 10;
    localparam int STORE_DEPTH = 1024;

    // dimension and read sequencing widths
    localparam int MAX_DIMS = 4;
    localparam int DIM_W    = 2;
    localparam int RD_W     = 4;

    // constant-divisor unit: x * recip >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 20;
    localparam int DIV_W       = ADDR_W + 1;
    localparam int PROD_W      = ADDR_W + RECIP_W;

    // field widths
    localparam int CMD_W  = 2;
    localparam int RND_W  = 16;
    localparam int THR_W  = 16;
    localparam int NSUM_W = 5;
    localparam int BOND_W = 4;
    localparam int CFG_W  = 2;

    // defaults for the top-level parameters
    localparam int SIDE_DEFAULT = 32;
    localparam int DIMS_DEFAULT = 2;

    // command codes (the unused code behaves as a query)
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic              capture;
        logic              dm_mul;
        logic              dm_sub;
        logic              dm_fix;
        logic              dm_total;
        logic [DIM_W-1:0]  dim;
        logic              wr_spin;
        logic              rd_issue;
        logic [RD_W-1:0]   rd_idx;
        logic              rd_take;
        logic [RD_W-1:0]   take_idx;
        logic              decide;
        logic              finish;
        logic              clr_we;
        logic [ADDR_W-1:0] clr_addr;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_write;
        logic is_update;
    } dp_status_t;

    // side raised to the number of dimensions
    function automatic longint unsigned isu_power(input int side, input int dims);
        longint unsigned acc;
        acc = 1;
        for (int i = 0; i < dims; i++) begin
            acc = acc * longint'(side);
        end
        return acc;
    endfunction

    // stride of one dimension, reduced to a store address
    function automatic logic [ADDR_W-1:0] isu_stride_mod(input int side, input int dim);
        longint unsigned s;
        s = isu_power(side, dim);
        return ADDR_W'(s & longint'(STORE_DEPTH - 1));
    endfunction

    // wrap distance (side-1)*stride, reduced to a store address
    function automatic logic [ADDR_W-1:0] isu_wrap_mod(input int side, input int dim);
        longint unsigned s;
        s = isu_power(side, dim) * longint'(side - 1);
        return ADDR_W'(s & longint'(STORE_DEPTH - 1));
    endfunction

endpackage

// ===== hdl/isu_ctrl.sv =====
// sequencer for the spin-flip update unit: clear pass, index split, reads, decision
// depends on isu_pkg
module isu_ctrl #(
    parameter int DIMS = isu_pkg::DIMS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  isu_pkg::dp_status_t  status,
    output isu_pkg::ctrl_cmd_t   cmd
);
    import isu_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_SUB    = 4'd3;
    localparam logic [3:0] S_FIX    = 4'd4;
    localparam logic [3:0] S_WRITE  = 4'd5;
    localparam logic [3:0] S_READ   = 4'd6;
    localparam logic [3:0] S_LAST   = 4'd7;
    localparam logic [3:0] S_DECIDE = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              total_reg, total_next;
    logic [DIM_W-1:0]  dim_reg, dim_next;
    logic [RD_W-1:0]   rd_reg, rd_next;
    logic              done_reg, done_next;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        total_next = total_reg;
        dim_next   = dim_reg;
        rd_next    = rd_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.dm_total = total_reg;
        cmd.dim      = dim_reg;
        cmd.rd_idx   = rd_reg;
        cmd.take_idx = rd_reg - 1'b1;
        cmd.clr_addr = clr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    total_next  = 1'b1;
                    dim_next    = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.dm_mul = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.dm_sub = 1'b1;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.dm_fix = 1'b1;
                if (total_reg)
                begin
                    total_next = 1'b0;
                    state_next = S_MUL;
                end
                else if (dim_reg == DIM_W'(DIMS - 1))
                begin
                    rd_next    = '0;
                    state_next = status.is_write ? S_WRITE : S_READ;
                end
                else
                begin
                    dim_next   = dim_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_WRITE:
            begin
                cmd.wr_spin = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                // issue one read, take the previous one
                cmd.rd_issue = 1'b1;
                cmd.rd_take  = (rd_reg != '0);
                rd_next      = rd_reg + 1'b1;
                if (rd_reg == RD_W'(2 * DIMS))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cmd.rd_take = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            total_reg <= 1'b0;
            dim_reg   <= '0;
            rd_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            dim_reg   <= dim_next;
            rd_reg    <= rd_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== hdl/isu_datapath.sv =====
// datapath of the spin-flip update unit: spin store, index split, neighbor sums,
// acceptance test and result registers; depends on isu_pkg
module isu_datapath #(
    parameter int SIDE = isu_pkg::SIDE_DEFAULT,
    parameter int DIMS = isu_pkg::DIMS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  isu_pkg::ctrl_cmd_t                  cmd,
    output isu_pkg::dp_status_t                 status,
    input  logic [isu_pkg::CMD_W-1:0]           command,
    input  logic [isu_pkg::ADDR_W-1:0]          site_index,
    input  logic                                spin_value,
    input  logic [isu_pkg::RND_W-1:0]           random_value,
    input  logic                                cfg_valid,
    input  logic [isu_pkg::CFG_W-1:0]           cfg_index,
    input  logic [isu_pkg::THR_W-1:0]           cfg_data,
    output logic                                spin_after,
    output logic                                flipped,
    output logic signed [isu_pkg::NSUM_W-1:0]   neighbour_sum,
    output logic signed [isu_pkg::BOND_W-1:0]   bond_energy
);
    import isu_pkg::*;

    localparam int NB_N = 2 * DIMS;
    localparam int NB_W = $clog2(NB_N);

    // constant divisors, clipped where the quotient is always zero
    localparam longint unsigned Total = isu_power(SIDE, DIMS);
    localparam int unsigned RecipTotal =
        (Total >= longint'(STORE_DEPTH)) ? 0 : int'((64'd1 << RECIP_SHIFT) / Total);
    localparam int unsigned ClipTotal =
        (Total >= longint'(STORE_DEPTH)) ? STORE_DEPTH : int'(Total);
    localparam int unsigned RecipSide =
        (SIDE >= STORE_DEPTH) ? 0 : (1 << RECIP_SHIFT) / SIDE;
    localparam int unsigned ClipSide = (SIDE >= STORE_DEPTH) ? STORE_DEPTH : SIDE;

    logic [CMD_W-1:0]   cmd_reg;
    logic [ADDR_W-1:0]  x_reg;
    logic               wval_reg;
    logic [RND_W-1:0]   rnd_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ADDR_W-1:0]  quo_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [ADDR_W-1:0]  linear_reg;
    logic [ADDR_W-1:0]  digit_reg [MAX_DIMS];
    logic               site_reg;
    logic [NB_N-1:0]    nb_reg;
    logic [NB_N-1:0]    alias_reg;
    logic               flip_reg;
    logic [THR_W-1:0]   thr_reg [4];
    logic               spin_mem [STORE_DEPTH];
    logic               rd_data_reg;

    logic                     spin_after_reg;
    logic                     flipped_reg;
    logic signed [NSUM_W-1:0] nsum_out_reg;
    logic signed [BOND_W-1:0] bond_out_reg;

    logic [ADDR_W-1:0] step_c [MAX_DIMS];
    logic [ADDR_W-1:0] wrap_c [MAX_DIMS];

    logic [RECIP_W-1:0] recip_sel;
    logic [DIV_W-1:0]   clip_sel;
    logic               fix_need;
    logic [DIV_W-1:0]   rem_fixed;
    logic [ADDR_W-1:0]  quo_fixed;

    logic [RD_W-1:0]   rd_j;
    logic [RD_W-1:0]   take_j;
    logic [DIM_W-1:0]  dim_sel;
    logic [ADDR_W-1:0] digit_sel;
    logic [ADDR_W-1:0] rd_addr;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic              mem_wd;

    logic [3:0]               ones_all;
    logic [2:0]               ones_fwd;
    logic signed [NSUM_W-1:0] nsum_c;
    logic signed [BOND_W-1:0] fsum_c;
    logic signed [NSUM_W-1:0] aligned_c;
    logic [THR_W-1:0]         thr_sel;
    logic                     accept_c;
    logic                     flip_now;

    assign status.is_write  = (cmd_reg == CMD_WRITE);
    assign status.is_update = (cmd_reg == CMD_UPDATE);

    // per-dimension step and wrap distances in store address space
    for (genvar g = 0; g < MAX_DIMS; g++)
    begin : g_dist
        assign step_c[g] = isu_stride_mod(SIDE, g);
        assign wrap_c[g] = isu_wrap_mod(SIDE, g);
    end

    // divisor select and quotient correction
    assign recip_sel = cmd.dm_total ? RECIP_W'(RecipTotal) : RECIP_W'(RecipSide);
    assign clip_sel  = cmd.dm_total ? DIV_W'(ClipTotal) : DIV_W'(ClipSide);
    assign fix_need  = (rem_reg >= clip_sel);
    assign rem_fixed = fix_need ? (rem_reg - clip_sel) : rem_reg;
    assign quo_fixed = quo_reg + ADDR_W'(fix_need);

    // neighbor address: site first, then forward and backward per dimension
    assign rd_j      = cmd.rd_idx - 1'b1;
    assign take_j    = cmd.take_idx - 1'b1;
    assign dim_sel   = rd_j[DIM_W:1];
    assign digit_sel = digit_reg[dim_sel];

    always_comb
    begin
        if (cmd.rd_idx == '0)
        begin
            rd_addr = linear_reg;
        end
        else if (!rd_j[0])
        begin
            rd_addr = (digit_sel == ADDR_W'(SIDE - 1)) ? (linear_reg - wrap_c[dim_sel])
                                                        : (linear_reg + step_c[dim_sel]);
        end
        else
        begin
            rd_addr = (digit_sel == '0) ? (linear_reg + wrap_c[dim_sel])
                                        : (linear_reg - step_c[dim_sel]);
        end
    end

    // neighbor counts from the collected spins
    always_comb
    begin
        ones_all = '0;
        ones_fwd = '0;
        for (int i = 0; i < NB_N; i++)
        begin
            ones_all = ones_all + 4'(nb_reg[i]);
            if ((i % 2) == 0)
            begin
                ones_fwd = ones_fwd + 3'(nb_reg[i]);
            end
        end
        nsum_c = $signed(5'({ones_all, 1'b0}) - 5'(2 * DIMS));
        fsum_c = $signed(4'({ones_fwd, 1'b0}) - 4'(DIMS));
    end

    // acceptance test on s * sum, energy rise of 2 * s * sum
    assign aligned_c = site_reg ? nsum_c : -nsum_c;

    always_comb
    begin
        case (aligned_c[3:1])
            3'd1:    thr_sel = thr_reg[0];
            3'd2:    thr_sel = thr_reg[1];
            3'd3:    thr_sel = thr_reg[2];
            default: thr_sel = thr_reg[3];
        endcase
        accept_c = aligned_c[NSUM_W-1] || (aligned_c == '0) || (rnd_reg < thr_sel);
    end

    assign flip_now = cmd.decide && status.is_update && accept_c;

    // store write port: clear pass, site write, or flip
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = linear_reg;
        mem_wd = wval_reg;
        if (cmd.clr_we)
        begin
            mem_we = 1'b1;
            mem_wa = cmd.clr_addr;
            mem_wd = 1'b1;
        end
        else if (cmd.wr_spin)
        begin
            mem_we = 1'b1;
        end
        else if (flip_now)
        begin
            mem_we = 1'b1;
            mem_wd = !site_reg;
        end
    end

    // spin store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            spin_mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= spin_mem[rd_addr];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= command;
            x_reg    <= site_index;
            wval_reg <= spin_value;
            rnd_reg  <= random_value;
        end
        if (cmd.dm_mul)
        begin
            prod_reg <= PROD_W'(x_reg) * PROD_W'(recip_sel);
        end
        if (cmd.dm_sub)
        begin
            quo_reg <= prod_reg[PROD_W-1:RECIP_SHIFT];
            rem_reg <= DIV_W'(x_reg)
                       - DIV_W'(prod_reg[PROD_W-1:RECIP_SHIFT] * clip_sel);
        end
        if (cmd.dm_fix)
        begin
            if (cmd.dm_total)
            begin
                linear_reg <= rem_fixed[ADDR_W-1:0];
                x_reg      <= rem_fixed[ADDR_W-1:0];
            end
            else
            begin
                digit_reg[cmd.dim] <= rem_fixed[ADDR_W-1:0];
                x_reg              <= quo_fixed;
            end
        end
        if (cmd.rd_issue && (cmd.rd_idx != '0))
        begin
            alias_reg[rd_j[NB_W-1:0]] <= (rd_addr == linear_reg);
        end
        if (cmd.rd_take)
        begin
            if (cmd.take_idx == '0)
            begin
                site_reg <= rd_data_reg;
            end
            else
            begin
                nb_reg[take_j[NB_W-1:0]] <= rd_data_reg;
            end
        end
        // a flip also shows in any neighbor that shares the site's address
        if (cmd.decide)
        begin
            flip_reg <= flip_now;
            site_reg <= site_reg ^ flip_now;
            nb_reg   <= nb_reg ^ (alias_reg & {NB_N{flip_now}});
        end
        if (cmd.finish)
        begin
            spin_after_reg <= site_reg;
            flipped_reg    <= flip_reg;
            nsum_out_reg   <= nsum_c;
            bond_out_reg   <= site_reg ? fsum_c : -fsum_c;
        end
    end

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                thr_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            thr_reg[cfg_index] <= cfg_data;
        end
    end

    assign spin_after    = spin_after_reg;
    assign flipped       = flipped_reg;
    assign neighbour_sum = nsum_out_reg;
    assign bond_energy   = bond_out_reg;

endmodule

// ===== hdl/ising_metropolis_site_update_unit.sv =====
// top level of the spin-flip update unit: controller plus datapath
// depends on isu_pkg, isu_ctrl and isu_datapath
//
// Keeps a periodic grid of DIMS dimensions with SIDE sites each as one spin bit
// per site (1 up, 0 down) in a 1024-entry store; larger grids alias modulo 1024.
// After reset the unit sweeps every store entry to all-up with busy high.
// A command transfers at a rising edge with start high and busy low. Its result
// follows passes of the shared constant divider, one per index digit plus one,
// a store write for a site write, and one store read per neighbor and for the
// site. The result shows for exactly one cycle with done high; the receiver
// cannot stall it, so it must take it then. busy is already low in that cycle,
// so the next command may transfer there. The user must write thresholds through
// the cfg port (always ready) only while idle; the block does not enforce it.
module ising_metropolis_site_update_unit #(
    parameter int SIDE = isu_pkg::SIDE_DEFAULT,
    parameter int DIMS = isu_pkg::DIMS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [isu_pkg::CMD_W-1:0]           command,
    input  logic [isu_pkg::ADDR_W-1:0]          site_index,
    input  logic                                spin_value,
    input  logic [isu_pkg::RND_W-1:0]           random_value,
    output logic                                done,
    output logic                                spin_after,
    output logic                                flipped,
    output logic signed [isu_pkg::NSUM_W-1:0]   neighbour_sum,
    output logic signed [isu_pkg::BOND_W-1:0]   bond_energy,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [isu_pkg::CFG_W-1:0]           cfg_index,
    input  logic [isu_pkg::THR_W-1:0]           cfg_data
);
    import isu_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // threshold writes never wait
    assign cfg_ready = 1'b1;

    isu_ctrl #(
        .DIMS (DIMS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd)
    );

    isu_datapath #(
        .SIDE (SIDE),
        .DIMS (DIMS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (command),
        .site_index    (site_index),
        .spin_value    (spin_value),
        .random_value  (random_value),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .spin_after    (spin_after),
        .flipped       (flipped),
        .neighbour_sum (neighbour_sum),
        .bond_energy   (bond_energy)
    );

endmodule

// ===== hdl/isu_checker.sv =====
// port-level checks for the spin-flip update unit, bound to the top level
// depends on ising_metropolis_site_update_unit_assert.svh
`include "ising_metropolis_site_update_unit_assert.svh"

module isu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic signed [4:0] neighbour_sum,
    input logic signed [3:0] bond_energy
);

    // a result only appears once the unit is free again
    `ISU_ASSERT_IMP(a_done_not_busy, clk, rst_n, done, !busy)

    // a transferred command keeps the unit busy
    `ISU_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)

    // neighbor sum is even and within the 2*MAX_DIMS bound of 8 either way
    `ISU_ASSERT_IMP(a_nsum_legal, clk, rst_n, done, !neighbour_sum[0] && neighbour_sum >= -8 && neighbour_sum <= 8)

    // forward-bond energy within four bonds
    `ISU_ASSERT_IMP(a_bond_range, clk, rst_n, done, bond_energy >= -4 && bond_energy <= 4)

endmodule

bind ising_metropolis_site_update_unit isu_checker u_isu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .neighbour_sum (neighbour_sum),
    .bond_energy   (bond_energy)
);

// ===== tb/tb_ising_metropolis_site_update_unit.sv =====
// self-checking testbench for the spin-flip update unit: directed table, then random phases
// depends on isu_pkg and ising_metropolis_site_update_unit; checked by an in-bench predictor
module tb_ising_metropolis_site_update_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import isu_pkg::*;

    localparam int SIDE            = SIDE_DEFAULT;
    localparam int DIMS            = DIMS_DEFAULT;
    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 5 * DIMS + 8 + 20;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int PLAN_ROWS       = 18;

    // command code left unused by the block, answered as a query
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    // threshold register indexes
    localparam logic [CFG_W-1:0] REG_LEVEL_ONE   = 2'd0;
    localparam logic [CFG_W-1:0] REG_LEVEL_TWO   = 2'd1;
    localparam logic [CFG_W-1:0] REG_LEVEL_THREE = 2'd2;
    localparam logic [CFG_W-1:0] REG_LEVEL_FOUR  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] site;
        logic              spin;
        logic [RND_W-1:0]  rnd;
    } site_cmd_t;

    typedef struct packed {
        logic                     spin_after;
        logic                     flipped;
        logic signed [NSUM_W-1:0] nsum;
        logic signed [BOND_W-1:0] bond;
    } site_result_t;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] site;
        logic              spin;
        logic [RND_W-1:0]  rnd;
        logic [CFG_W-1:0]  reg_idx;
        logic [THR_W-1:0]  reg_data;
        logic              pinned;
        site_result_t      typed;
    } plan_row_t;

    localparam site_result_t NO_RESULT = '0;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     start        = 1'b0;
    logic                     busy;
    logic [CMD_W-1:0]         command      = CMD_QUERY;
    logic [ADDR_W-1:0]        site_index   = '0;
    logic                     spin_value   = 1'b0;
    logic [RND_W-1:0]         random_value = '0;
    logic                     done;
    logic                     spin_after;
    logic                     flipped;
    logic signed [NSUM_W-1:0] neighbour_sum;
    logic signed [BOND_W-1:0] bond_energy;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_index    = '0;
    logic [THR_W-1:0]         cfg_data     = '0;

    // predictor state: one spin bit per store entry and the four thresholds
    bit               site_spins [STORE_DEPTH];
    logic [THR_W-1:0] accept_threshold [4];

    site_result_t pending_results [$];
    int           mismatch_count = 0;

    plan_row_t directed_plan [PLAN_ROWS];

    ising_metropolis_site_update_unit #(
        .SIDE (SIDE),
        .DIMS (DIMS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .site_index    (site_index),
        .spin_value    (spin_value),
        .random_value  (random_value),
        .done          (done),
        .spin_after    (spin_after),
        .flipped       (flipped),
        .neighbour_sum (neighbour_sum),
        .bond_energy   (bond_energy),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // spin of a site as +1 or -1, sites beyond the store alias
    function automatic int spin_pm(input longint unsigned linear);
        return site_spins[linear % STORE_DEPTH] ? 1 : -1;
    endfunction

    // periodic neighbor one step along the dimension with the given stride
    function automatic longint unsigned neighbour_of(input longint unsigned linear,
                                                     input longint unsigned stride,
                                                     input bit fwd);
        longint unsigned c;
        longint unsigned nc;
        c  = (linear / stride) % SIDE;
        nc = fwd ? (c + 1) % SIDE : (c + SIDE - 1) % SIDE;
        return linear - c * stride + nc * stride;
    endfunction

    // sum over all neighbors and over the forward ones only
    function automatic void survey(input longint unsigned linear, output int all_sum,
                                   output int fwd_sum);
        longint unsigned stride;
        int              up;
        stride  = 1;
        all_sum = 0;
        fwd_sum = 0;
        for (int d = 0; d < DIMS; d++)
        begin
            up      = spin_pm(neighbour_of(linear, stride, 1'b1));
            all_sum = all_sum + up + spin_pm(neighbour_of(linear, stride, 1'b0));
            fwd_sum = fwd_sum + up;
            stride  = stride * SIDE;
        end
    endfunction

    // applies one command to the predictor state and returns the result it causes
    function automatic site_result_t metropolis_step(input site_cmd_t item);
        longint unsigned total;
        longint unsigned linear;
        int              s;
        int              all_sum;
        int              fwd_sum;
        int              rise;
        int              level;
        bit              accept;
        site_result_t    res;
        total = 1;
        for (int d = 0; d < DIMS; d++)
        begin
            total = total * SIDE;
        end
        linear      = item.site % total;
        res.flipped = 1'b0;
        if (item.command == CMD_WRITE)
        begin
            site_spins[linear % STORE_DEPTH] = item.spin;
        end
        else if (item.command == CMD_UPDATE)
        begin
            s = spin_pm(linear);
            survey(linear, all_sum, fwd_sum);
            rise = 2 * s * all_sum;
            if (rise <= 0)
            begin
                accept = 1'b1;
            end
            else
            begin
                level = rise / 4;
                if (level > 4)
                    level = 4;
                if (level < 1)
                    level = 1;
                accept = item.rnd < accept_threshold[level - 1];
            end
            if (accept)
            begin
                site_spins[linear % STORE_DEPTH] = ~site_spins[linear % STORE_DEPTH];
                res.flipped = 1'b1;
            end
        end
        // reported fields reflect the store after the command
        s = spin_pm(linear);
        survey(linear, all_sum, fwd_sum);
        res.spin_after = (s > 0);
        res.nsum       = NSUM_W'(all_sum);
        res.bond       = BOND_W'(s * fwd_sum);
        return res;
    endfunction

    // result typed into the table
    function automatic site_result_t typed_result(input bit sp, input bit fl, input int ns,
                                                  input int bd);
        site_result_t res;
        res.spin_after = sp;
        res.flipped    = fl;
        res.nsum       = NSUM_W'(ns);
        res.bond       = BOND_W'(bd);
        return res;
    endfunction

    // table row for one command
    function automatic plan_row_t cmd_row(input logic [CMD_W-1:0] c, input int site,
                                          input bit spin, input int rnd, input bit pinned,
                                          input site_result_t typed);
        plan_row_t r;
        r         = '0;
        r.kind    = ROW_CMD;
        r.command = c;
        r.site    = ADDR_W'(site);
        r.spin    = spin;
        r.rnd     = RND_W'(rnd);
        r.pinned  = pinned;
        r.typed   = typed;
        return r;
    endfunction

    // table row for one threshold write
    function automatic plan_row_t cfg_row(input logic [CFG_W-1:0] idx,
                                          input logic [THR_W-1:0] data);
        plan_row_t r;
        r          = '0;
        r.kind     = ROW_CFG;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    // idle gap: mostly short, some medium, a few long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return int'($urandom_range(0, 3));
        else if (sel < 92)
            return int'($urandom_range(4, 12));
        else
            return int'($urandom_range(30, 80));
    endfunction

    // present one command, wait for its transfer, log what it should return
    task automatic issue_command(input site_cmd_t item, input bit pinned,
                                 input site_result_t typed, input int gap);
        site_result_t predicted;
        start        <= 1'b1;
        command      <= item.command;
        site_index   <= item.site;
        spin_value   <= item.spin;
        random_value <= item.rnd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = metropolis_step(item);
        pending_results.push_back(pinned ? typed : predicted);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // block idle: no command in flight and nothing outstanding
    task automatic wait_idle();
        while (busy || pending_results.size() != 0)
            @(posedge clk);
    endtask

    // one threshold write; valid stays up when another write follows
    task automatic write_threshold(input logic [CFG_W-1:0] idx, input logic [THR_W-1:0] data,
                                   input bit keep_valid);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        accept_threshold[idx] = data;
        if (!keep_valid)
            cfg_valid <= 1'b0;
    endtask

    // stop issuing, drain, then load all four thresholds back to back
    task automatic load_thresholds(input logic [THR_W-1:0] l1, input logic [THR_W-1:0] l2,
                                   input logic [THR_W-1:0] l3, input logic [THR_W-1:0] l4);
        start <= 1'b0;
        wait_idle();
        write_threshold(REG_LEVEL_ONE, l1, 1'b1);
        write_threshold(REG_LEVEL_TWO, l2, 1'b1);
        write_threshold(REG_LEVEL_THREE, l3, 1'b1);
        write_threshold(REG_LEVEL_FOUR, l4, 1'b0);
    endtask

    // random command with clustered sites and random values near thresholds
    task automatic random_command(input logic [ADDR_W-1:0] cluster_base, output site_cmd_t item);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            item.command = CMD_WRITE;
        else if (sel < 70)
            item.command = CMD_UPDATE;
        else if (sel < 90)
            item.command = CMD_QUERY;
        else
            item.command = CMD_RESERVED;
        if ($urandom_range(0, 1) == 0)
            item.site = cluster_base + ADDR_W'($urandom_range(0, 47));
        else
            item.site = ADDR_W'($urandom);
        item.spin = 1'($urandom);
        sel = $urandom_range(0, 7);
        if (sel == 0)
            item.rnd = '0;
        else if (sel == 1)
            item.rnd = '1;
        else if (sel < 4)
            item.rnd = accept_threshold[$urandom_range(0, 3)]
                       + RND_W'($urandom_range(0, 2)) - RND_W'(1);
        else
            item.rnd = RND_W'($urandom);
    endtask

    // compare every done strobe against the oldest outstanding expectation
    always @(posedge clk)
    begin
        site_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no command outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (spin_after !== want.spin_after)
                begin
                    $error("spin_after: expected %0d, got %0d", want.spin_after, spin_after);
                    mismatch_count++;
                end
                if (flipped !== want.flipped)
                begin
                    $error("flipped: expected %0d, got %0d", want.flipped, flipped);
                    mismatch_count++;
                end
                if (neighbour_sum !== want.nsum)
                begin
                    $error("neighbour_sum: expected %0d, got %0d", want.nsum, neighbour_sum);
                    mismatch_count++;
                end
                if (bond_energy !== want.bond)
                begin
                    $error("bond_energy: expected %0d, got %0d", want.bond, bond_energy);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        plan_row_t         row;
        site_cmd_t         item;
        logic [ADDR_W-1:0] cluster_base;
        bit                keep_valid;

        // directed table: after reset all spins are up and thresholds are zero
        directed_plan[0]  = cmd_row(CMD_QUERY, 0, 1'b0, 0, 1'b1, typed_result(1, 0, 4, 2));
        directed_plan[1]  = cmd_row(CMD_RESERVED, 1023, 1'b0, 0, 1'b1,
                                    typed_result(1, 0, 4, 2));
        directed_plan[2]  = cmd_row(CMD_UPDATE, 5, 1'b0, 0, 1'b1, typed_result(1, 0, 4, 2));
        directed_plan[3]  = cfg_row(REG_LEVEL_ONE, 16'h4000);
        directed_plan[4]  = cfg_row(REG_LEVEL_TWO, 16'h2000);
        directed_plan[5]  = cfg_row(REG_LEVEL_THREE, 16'h1000);
        directed_plan[6]  = cfg_row(REG_LEVEL_FOUR, 16'hFFFF);
        directed_plan[7]  = cmd_row(CMD_WRITE, 33, 1'b0, 0, 1'b1, typed_result(0, 0, 4, -2));
        directed_plan[8]  = cmd_row(CMD_UPDATE, 33, 1'b0, 0, 1'b1, typed_result(1, 1, 4, 2));
        directed_plan[9]  = cmd_row(CMD_WRITE, 34, 1'b0, 0, 1'b0, NO_RESULT);
        directed_plan[10] = cmd_row(CMD_WRITE, 32, 1'b0, 0, 1'b0, NO_RESULT);
        directed_plan[11] = cmd_row(CMD_UPDATE, 33, 1'b0, 16'hFFFF, 1'b0, NO_RESULT);
        directed_plan[12] = cmd_row(CMD_WRITE, 0, 1'b0, 0, 1'b0, NO_RESULT);
        directed_plan[13] = cmd_row(CMD_UPDATE, 0, 1'b1, 16'hFFFF, 1'b0, NO_RESULT);
        directed_plan[14] = cmd_row(CMD_UPDATE, 1023, 1'b0, 16'hFFFE, 1'b0, NO_RESULT);
        directed_plan[15] = cmd_row(CMD_UPDATE, 1023, 1'b0, 0, 1'b0, NO_RESULT);
        directed_plan[16] = cmd_row(CMD_QUERY, 992, 1'b0, 0, 1'b0, NO_RESULT);
        directed_plan[17] = cfg_row(REG_LEVEL_FOUR, 16'h0000);

        // predictor reset state: cold start, thresholds cleared
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            site_spins[i] = 1'b1;
        end
        for (int i = 0; i < 4; i++)
        begin
            accept_threshold[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            row = directed_plan[r];
            if (row.kind == ROW_CFG)
            begin
                keep_valid = (r + 1 < PLAN_ROWS) && (directed_plan[r + 1].kind == ROW_CFG);
                start <= 1'b0;
                wait_idle();
                write_threshold(row.reg_idx, row.reg_data, keep_valid);
            end
            else
            begin
                item.command = row.command;
                item.site    = row.site;
                item.spin    = row.spin;
                item.rnd     = row.rnd;
                issue_command(item, row.pinned, row.typed, pick_gap());
            end
        end

        // random phases, each with its own thresholds and site cluster
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 1)
                load_thresholds('0, '0, '0, '0);
            else if (p == 2)
                load_thresholds('1, '1, '1, '1);
            else if (p == 3)
                load_thresholds(THR_W'($urandom_range(0, 255)), THR_W'($urandom_range(0, 255)),
                                THR_W'($urandom_range(0, 255)), THR_W'($urandom_range(0, 255)));
            else
                load_thresholds(THR_W'($urandom), THR_W'($urandom),
                                THR_W'($urandom), THR_W'($urandom));
            cluster_base = ADDR_W'($urandom);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                random_command(cluster_base, item);
                issue_command(item, 1'b0, NO_RESULT, pick_gap());
            end
        end

        // drain and report
        start <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/isu_pkg.sv
hdl/isu_ctrl.sv
hdl/isu_datapath.sv
hdl/ising_metropolis_site_update_unit.sv
hdl/isu_checker.sv
tb/tb_ising_metropolis_site_update_unit.sv
